### design/cubic_bezier_point_normal_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cubic Bezier point and normal evaluator
// Implication checks, plain and with a fixed delay, used at the end of the
// top level.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_POINT_NORMAL_ASSERT_SVH
`define CUBIC_BEZIER_POINT_NORMAL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CBPN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold a fixed number of cycles after the antecedent.
`define CBPN_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

### design/cbpn_pkg.sv
// ----------------------------------------------------------------------------
// cbpn_pkg
// Register indexes, fixed internal widths and the direction flags that travel
// down the normal pipeline of the cubic Bezier evaluator.
// ----------------------------------------------------------------------------
package cbpn_pkg;

    // Width of the configuration register index.
    localparam int REG_IDX_W = 3;

    // The larger derivative magnitude is normalized into [2^30, 2^31).
    localparam int NORM_W = 31;
    // Integer square root of a sum of two normalized squares.
    localparam int ROOT_W = 32;
    localparam int RAD_W  = 64;

    // Configuration register map.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_CTRL0_X = 3'd0,
        REG_CTRL0_Y = 3'd1,
        REG_CTRL1_X = 3'd2,
        REG_CTRL1_Y = 3'd3,
        REG_CTRL2_X = 3'd4,
        REG_CTRL2_Y = 3'd5,
        REG_CTRL3_X = 3'd6,
        REG_CTRL3_Y = 3'd7
    } t_reg_idx;

    // Sign and degenerate flags of the derivative.
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic deg;
    } t_dir;

endpackage

### design/cubic_bezier_point_normal.sv
// ----------------------------------------------------------------------------
// cubic_bezier_point_normal
// Fixed point cubic Bezier point and unit normal, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
// - Control points P0..P3 are written through the write port (i_cfg_we,
//   i_cfg_idx, i_cfg_data); a write takes effect at the clock edge. Write
//   them only while no request is in flight.
// - A request is taken at a rising edge with start high and busy low. busy
//   is high only while reset is asserted, so one request per cycle is taken.
// - Each request yields one result, shown for one cycle with o_strobe high:
//   point (integer like the control points, saturated), unit normal
//   (-dy, dx)/|d| in Q(COORD_BITS-FRAC_BITS).FRAC_BITS and the degenerate
//   flag, which is set with a zero normal when the derivative is zero.
// - The normalizer has NS stages, where NS is
//   clog2(max(COORD_BITS + FRAC_BITS + 3, 31)); it is followed by the 32-stage
//   square root and the (FRAC_BITS + 1)-stage divider.
// - Throughput is one request per cycle; results leave in request order.
// - Reset clears the control points and all valid bits; requests in flight
//   are dropped. The receiver cannot stall the output.
// ----------------------------------------------------------------------------
module cubic_bezier_point_normal
    import cbpn_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [FRAC_BITS:0]           i_param_t,
    input  logic                         i_cfg_we,
    input  logic [REG_IDX_W-1:0]         i_cfg_idx,
    input  logic [COORD_BITS-1:0]        i_cfg_data,
    output logic                         o_strobe,
    output logic signed [COORD_BITS-1:0] o_point_x,
    output logic signed [COORD_BITS-1:0] o_point_y,
    output logic signed [COORD_BITS-1:0] o_normal_x,
    output logic signed [COORD_BITS-1:0] o_normal_y,
    output logic                         o_degenerate
);

    localparam int CW   = COORD_BITS;
    localparam int FW   = FRAC_BITS;
    localparam int TW   = FW + 1;              // t, u and basis weights
    localparam int PW   = 2 * TW;              // weight products
    localparam int DFW  = CW + 1;              // control point differences
    localparam int DW   = CW + FW + 3;         // derivative
    localparam int BW   = CW + FW + 2;         // weight times coordinate
    localparam int SXW  = CW + FW + 4;         // point sum
    localparam int RPW  = SXW - FW;            // rounded point sum
    localparam int NW   = (DW > NORM_W) ? DW : NORM_W;
    localparam int NS   = $clog2(NW);
    localparam int NUMW = ROOT_W + FW;         // dividend
    localparam int UW   = ((TW + 1 > CW) ? TW + 1 : CW) + 1;
    localparam int LAT  = 11 + NS + ROOT_W + TW;
    localparam int PD   = LAT - 8;

    localparam logic [TW-1:0] ONE_T = TW'(1) << FW;
    localparam logic [PW:0]   HALF1 = (PW + 1)'(1) << (FW - 1);
    localparam logic [PW+1:0] HALF2 = (PW + 2)'(1) << (FW - 1);
    localparam logic [SXW-1:0] HALF_S = SXW'(1) << (FW - 1);
    localparam logic signed [RPW-1:0] PT_MAX = RPW'((longint'(1) <<< (CW - 1)) - 1);
    localparam logic signed [RPW-1:0] PT_MIN = RPW'(-(longint'(1) <<< (CW - 1)));
    localparam logic signed [UW-1:0]  NM_MAX = UW'((longint'(1) <<< (CW - 1)) - 1);
    localparam logic signed [UW-1:0]  NM_MIN = UW'(-(longint'(1) <<< (CW - 1)));

    function automatic logic signed [CW-1:0] sat_pt(input logic signed [RPW-1:0] v);
        if (v > PT_MAX) return PT_MAX[CW-1:0];
        if (v < PT_MIN) return PT_MIN[CW-1:0];
        return v[CW-1:0];
    endfunction

    function automatic logic signed [CW-1:0] sat_nm(input logic signed [UW-1:0] v);
        if (v > NM_MAX) return NM_MAX[CW-1:0];
        if (v < NM_MIN) return NM_MIN[CW-1:0];
        return v[CW-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Control point registers and their differences
    // ------------------------------------------------------------------------
    logic signed [CW-1:0]  r_ctrl_x [0:3];
    logic signed [CW-1:0]  r_ctrl_y [0:3];
    logic signed [DFW-1:0] r_dfx [0:2];
    logic signed [DFW-1:0] r_dfy [0:2];

    // A write to an index lands in exactly one register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_ctrl_x[k] <= '0;
                r_ctrl_y[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_CTRL0_X: r_ctrl_x[0] <= i_cfg_data;
                REG_CTRL0_Y: r_ctrl_y[0] <= i_cfg_data;
                REG_CTRL1_X: r_ctrl_x[1] <= i_cfg_data;
                REG_CTRL1_Y: r_ctrl_y[1] <= i_cfg_data;
                REG_CTRL2_X: r_ctrl_x[2] <= i_cfg_data;
                REG_CTRL2_Y: r_ctrl_y[2] <= i_cfg_data;
                REG_CTRL3_X: r_ctrl_x[3] <= i_cfg_data;
                REG_CTRL3_Y: r_ctrl_y[3] <= i_cfg_data;
            endcase
        end
    end

    // Differences are registered from the control points; they are only
    // read in stage 4 of a request.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_dfx[k] <= DFW'(r_ctrl_x[k + 1]) - DFW'(r_ctrl_x[k]);
            r_dfy[k] <= DFW'(r_ctrl_y[k + 1]) - DFW'(r_ctrl_y[k]);
        end
    end

    // ------------------------------------------------------------------------
    // Request handshake and valid line
    // ------------------------------------------------------------------------
    logic          w_acc;
    logic [LAT:1]  r_vld;

    assign busy  = !i_rst_n;
    assign w_acc = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-1:1], w_acc};
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: clamp t to one and form u = 1 - t
    // ------------------------------------------------------------------------
    logic [TW-1:0] n_t1;
    logic [TW-1:0] r_t1, r_u1;

    assign n_t1 = (i_param_t > ONE_T) ? ONE_T : i_param_t;

    always_ff @(posedge i_clk) begin
        r_t1 <= n_t1;
        r_u1 <= ONE_T - n_t1;
    end

    // ------------------------------------------------------------------------
    // Stage 2: u*u, t*t, u*t
    // ------------------------------------------------------------------------
    logic [PW-1:0] r_uuw2, r_ttw2, r_utw2;
    logic [TW-1:0] r_t2, r_u2;

    always_ff @(posedge i_clk) begin
        r_uuw2 <= r_u1 * r_u1;
        r_ttw2 <= r_t1 * r_t1;
        r_utw2 <= r_u1 * r_t1;
        r_t2   <= r_t1;
        r_u2   <= r_u1;
    end

    // ------------------------------------------------------------------------
    // Stage 3: round the squares and 2*u*t back to Q1.FRAC_BITS
    // ------------------------------------------------------------------------
    logic [PW:0]   n_uu_sum, n_tt_sum, n_ut_sum;
    logic [TW-1:0] r_uu3, r_tt3, r_ut3, r_t3, r_u3;

    assign n_uu_sum = {1'b0, r_uuw2} + HALF1;
    assign n_tt_sum = {1'b0, r_ttw2} + HALF1;
    assign n_ut_sum = {r_utw2, 1'b0} + HALF1;

    always_ff @(posedge i_clk) begin
        r_uu3 <= n_uu_sum[FW +: TW];
        r_tt3 <= n_tt_sum[FW +: TW];
        r_ut3 <= n_ut_sum[FW +: TW];
        r_t3  <= r_t2;
        r_u3  <= r_u2;
    end

    // ------------------------------------------------------------------------
    // Stage 4: cubic weight products and derivative terms
    // ------------------------------------------------------------------------
    logic [PW-1:0]        r_p4 [0:3];
    logic signed [DW-1:0] r_ddx4 [0:2];
    logic signed [DW-1:0] r_ddy4 [0:2];

    always_ff @(posedge i_clk) begin
        r_p4[0]   <= r_uu3 * r_u3;
        r_p4[1]   <= r_uu3 * r_t3;
        r_p4[2]   <= r_u3 * r_tt3;
        r_p4[3]   <= r_tt3 * r_t3;
        r_ddx4[0] <= $signed({1'b0, r_uu3}) * r_dfx[0];
        r_ddx4[1] <= $signed({1'b0, r_ut3}) * r_dfx[1];
        r_ddx4[2] <= $signed({1'b0, r_tt3}) * r_dfx[2];
        r_ddy4[0] <= $signed({1'b0, r_uu3}) * r_dfy[0];
        r_ddy4[1] <= $signed({1'b0, r_ut3}) * r_dfy[1];
        r_ddy4[2] <= $signed({1'b0, r_tt3}) * r_dfy[2];
    end

    // ------------------------------------------------------------------------
    // Stage 5: Bernstein weights and derivative sums
    // ------------------------------------------------------------------------
    logic [PW:0]          n_b0s, n_b3s;
    logic [PW+1:0]        n_b1s, n_b2s;
    logic [TW-1:0]        r_b5 [0:3];
    logic signed [DW-1:0] r_dx5, r_dy5;

    assign n_b0s = {1'b0, r_p4[0]} + HALF1;
    assign n_b3s = {1'b0, r_p4[3]} + HALF1;
    assign n_b1s = {2'b0, r_p4[1]} + {1'b0, r_p4[1], 1'b0} + HALF2;
    assign n_b2s = {2'b0, r_p4[2]} + {1'b0, r_p4[2], 1'b0} + HALF2;

    always_ff @(posedge i_clk) begin
        r_b5[0] <= n_b0s[FW +: TW];
        r_b5[1] <= n_b1s[FW +: TW];
        r_b5[2] <= n_b2s[FW +: TW];
        r_b5[3] <= n_b3s[FW +: TW];
        r_dx5   <= r_ddx4[0] + r_ddx4[1] + r_ddx4[2];
        r_dy5   <= r_ddy4[0] + r_ddy4[1] + r_ddy4[2];
    end

    // ------------------------------------------------------------------------
    // Stage 6: weight times control point; derivative magnitudes and signs
    // ------------------------------------------------------------------------
    logic signed [BW-1:0] r_qx6 [0:3];
    logic signed [BW-1:0] r_qy6 [0:3];
    logic [DW-1:0]        r_ax6, r_ay6;
    t_dir                 r_dir6;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_qx6[k] <= $signed({1'b0, r_b5[k]}) * r_ctrl_x[k];
            r_qy6[k] <= $signed({1'b0, r_b5[k]}) * r_ctrl_y[k];
        end
        r_ax6        <= r_dx5[DW-1] ? $unsigned(-r_dx5) : $unsigned(r_dx5);
        r_ay6        <= r_dy5[DW-1] ? $unsigned(-r_dy5) : $unsigned(r_dy5);
        r_dir6.neg_x <= r_dx5[DW-1];
        r_dir6.neg_y <= r_dy5[DW-1];
        r_dir6.deg   <= (r_dx5 == '0) && (r_dy5 == '0);
    end

    // ------------------------------------------------------------------------
    // Stage 7: point sums; larger magnitude enters the normalizer
    // ------------------------------------------------------------------------
    logic signed [SXW-1:0] r_sx7, r_sy7;
    logic [DW-1:0]         n_m6;
    logic [NW-1:0]         r_nm [0:NS];
    logic [NW-1:0]         r_na_x [0:NS];
    logic [NW-1:0]         r_na_y [0:NS];
    t_dir                  r_ndir [0:NS];

    assign n_m6 = (r_ax6 > r_ay6) ? r_ax6 : r_ay6;

    always_ff @(posedge i_clk) begin
        r_sx7     <= SXW'(r_qx6[0]) + SXW'(r_qx6[1]) + SXW'(r_qx6[2]) + SXW'(r_qx6[3]);
        r_sy7     <= SXW'(r_qy6[0]) + SXW'(r_qy6[1]) + SXW'(r_qy6[2]) + SXW'(r_qy6[3]);
        r_nm[0]   <= NW'(n_m6);
        r_na_x[0] <= NW'(r_ax6);
        r_na_y[0] <= NW'(r_ay6);
        r_ndir[0] <= r_dir6;
    end

    // ------------------------------------------------------------------------
    // Stage 8: round the point half away from zero and saturate
    // ------------------------------------------------------------------------
    logic signed [SXW-1:0] n_rsx, n_rsy;
    logic signed [RPW-1:0] n_psx, n_psy;
    logic signed [CW-1:0]  r_px8, r_py8;

    assign n_rsx = r_sx7 + HALF_S - SXW'(r_sx7[SXW-1]);
    assign n_rsy = r_sy7 + HALF_S - SXW'(r_sy7[SXW-1]);
    assign n_psx = n_rsx[SXW-1:FW];
    assign n_psy = n_rsy[SXW-1:FW];

    always_ff @(posedge i_clk) begin
        r_px8 <= sat_pt(n_psx);
        r_py8 <= sat_pt(n_psy);
    end

    // The point waits for the normal in a delay line.
    logic signed [CW-1:0] r_pxd [0:PD-1];
    logic signed [CW-1:0] r_pyd [0:PD-1];

    always_ff @(posedge i_clk) begin
        r_pxd[0] <= r_px8;
        r_pyd[0] <= r_py8;
        for (int k = 1; k < PD; k++) begin
            r_pxd[k] <= r_pxd[k - 1];
            r_pyd[k] <= r_pyd[k - 1];
        end
    end

    // ------------------------------------------------------------------------
    // Normalizer: move the leading one of the larger magnitude to the top,
    // halving the shift range at each stage
    // ------------------------------------------------------------------------
    for (genvar s = 0; s < NS; s++) begin : g_norm
        localparam int SH = 1 << (NS - 1 - s);

        always_ff @(posedge i_clk) begin
            if (r_nm[s][NW-1 -: SH] == '0) begin
                r_nm[s + 1]   <= r_nm[s] << SH;
                r_na_x[s + 1] <= r_na_x[s] << SH;
                r_na_y[s + 1] <= r_na_y[s] << SH;
            end else begin
                r_nm[s + 1]   <= r_nm[s];
                r_na_x[s + 1] <= r_na_x[s];
                r_na_y[s + 1] <= r_na_y[s];
            end
            r_ndir[s + 1] <= r_ndir[s];
        end
    end

    // ------------------------------------------------------------------------
    // Squares of the normalized magnitudes, then their sum
    // ------------------------------------------------------------------------
    logic [NORM_W-1:0]   w_nx, w_ny;
    logic [2*NORM_W-1:0] r_sqx, r_sqy;
    logic [NORM_W-1:0]   r_qax, r_qay;
    t_dir                r_qdir;

    assign w_nx = r_na_x[NS][NW-1 -: NORM_W];
    assign w_ny = r_na_y[NS][NW-1 -: NORM_W];

    always_ff @(posedge i_clk) begin
        r_sqx  <= w_nx * w_nx;
        r_sqy  <= w_ny * w_ny;
        r_qax  <= w_nx;
        r_qay  <= w_ny;
        r_qdir <= r_ndir[NS];
    end

    logic [RAD_W-1:0]  r_rad  [0:ROOT_W];
    logic [ROOT_W-1:0] r_root [0:ROOT_W];
    logic [NORM_W-1:0] r_sa_x [0:ROOT_W];
    logic [NORM_W-1:0] r_sa_y [0:ROOT_W];
    t_dir              r_sdir [0:ROOT_W];

    always_ff @(posedge i_clk) begin
        r_rad[0]  <= RAD_W'(r_sqx) + RAD_W'(r_sqy);
        r_root[0] <= '0;
        r_sa_x[0] <= r_qax;
        r_sa_y[0] <= r_qay;
        r_sdir[0] <= r_qdir;
    end

    // ------------------------------------------------------------------------
    // Integer square root, one result bit per stage, most significant first
    // ------------------------------------------------------------------------
    for (genvar s = 0; s < ROOT_W; s++) begin : g_sqrt
        localparam int BI = ROOT_W - 1 - s;
        logic [RAD_W:0] w_try;

        assign w_try = ((RAD_W + 1)'(r_root[s]) << (BI + 1))
                     + ((RAD_W + 1)'(1) << (2 * BI));

        always_ff @(posedge i_clk) begin
            if ({1'b0, r_rad[s]} >= w_try) begin
                r_rad[s + 1]  <= r_rad[s] - w_try[RAD_W-1:0];
                r_root[s + 1] <= r_root[s] | (ROOT_W'(1) << BI);
            end else begin
                r_rad[s + 1]  <= r_rad[s];
                r_root[s + 1] <= r_root[s];
            end
            r_sa_x[s + 1] <= r_sa_x[s];
            r_sa_y[s + 1] <= r_sa_y[s];
            r_sdir[s + 1] <= r_sdir[s];
        end
    end

    // ------------------------------------------------------------------------
    // Dividends a * ONE + L/2 for both components
    // ------------------------------------------------------------------------
    logic [NUMW-1:0]   r_rmx [0:TW];
    logic [NUMW-1:0]   r_rmy [0:TW];
    logic [TW-1:0]     r_qtx [0:TW];
    logic [TW-1:0]     r_qty [0:TW];
    logic [ROOT_W-1:0] r_dl  [0:TW];
    t_dir              r_ddir [0:TW];

    always_ff @(posedge i_clk) begin
        r_rmx[0]  <= (NUMW'(r_sa_x[ROOT_W]) << FW) + NUMW'(r_root[ROOT_W] >> 1);
        r_rmy[0]  <= (NUMW'(r_sa_y[ROOT_W]) << FW) + NUMW'(r_root[ROOT_W] >> 1);
        r_qtx[0]  <= '0;
        r_qty[0]  <= '0;
        r_dl[0]   <= r_root[ROOT_W];
        r_ddir[0] <= r_sdir[ROOT_W];
    end

    // ------------------------------------------------------------------------
    // Restoring division by L, one quotient bit per stage in both lanes
    // ------------------------------------------------------------------------
    for (genvar s = 0; s < TW; s++) begin : g_div
        localparam int J = TW - 1 - s;
        logic [NUMW-1:0] w_dv;

        assign w_dv = NUMW'(r_dl[s]) << J;

        always_ff @(posedge i_clk) begin
            if (r_rmx[s] >= w_dv) begin
                r_rmx[s + 1] <= r_rmx[s] - w_dv;
                r_qtx[s + 1] <= r_qtx[s] | (TW'(1) << J);
            end else begin
                r_rmx[s + 1] <= r_rmx[s];
                r_qtx[s + 1] <= r_qtx[s];
            end
            if (r_rmy[s] >= w_dv) begin
                r_rmy[s + 1] <= r_rmy[s] - w_dv;
                r_qty[s + 1] <= r_qty[s] | (TW'(1) << J);
            end else begin
                r_rmy[s + 1] <= r_rmy[s];
                r_qty[s + 1] <= r_qty[s];
            end
            r_dl[s + 1]   <= r_dl[s];
            r_ddir[s + 1] <= r_ddir[s];
        end
    end

    // ------------------------------------------------------------------------
    // Final stage: quarter turn, signs, saturation, degenerate case
    // ------------------------------------------------------------------------
    logic signed [UW-1:0] n_ux, n_uy, n_nx, n_ny;
    logic signed [CW-1:0] r_nxo, r_nyo;
    logic                 r_dego;

    assign n_ux = $signed(UW'(r_qtx[TW]));
    assign n_uy = $signed(UW'(r_qty[TW]));
    assign n_ny = r_ddir[TW].neg_x ? -n_ux : n_ux;
    assign n_nx = r_ddir[TW].neg_y ? n_uy : -n_uy;

    always_ff @(posedge i_clk) begin
        if (r_ddir[TW].deg) begin
            r_nxo <= '0;
            r_nyo <= '0;
        end else begin
            r_nxo <= sat_nm(n_nx);
            r_nyo <= sat_nm(n_ny);
        end
        r_dego <= r_ddir[TW].deg;
    end

    assign o_strobe     = r_vld[LAT];
    assign o_point_x    = r_pxd[PD-1];
    assign o_point_y    = r_pyd[PD-1];
    assign o_normal_x   = r_nxo;
    assign o_normal_y   = r_nyo;
    assign o_degenerate = r_dego;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`include "cubic_bezier_point_normal_assert.svh"

    `CBPN_ASSERT_DLY(a_req_to_result, i_clk, i_rst_n, start && !busy, LAT, o_strobe, "request did not produce a result after the pipeline latency")
    `CBPN_ASSERT_IMP(a_result_has_req, i_clk, i_rst_n, o_strobe, $past(start && !busy, LAT), "result strobe without a matching request")
    `CBPN_ASSERT_IMP(a_deg_zero_normal, i_clk, i_rst_n, o_strobe && o_degenerate, (o_normal_x == '0) && (o_normal_y == '0), "degenerate result carries a nonzero normal")
    `CBPN_ASSERT_IMP(a_normal_nonzero, i_clk, i_rst_n, o_strobe && !o_degenerate, (o_normal_x != '0) || (o_normal_y != '0), "regular result carries a zero normal")

endmodule

### dv/cubic_bezier_point_normal_tb.sv
// ----------------------------------------------------------------------------
// cubic_bezier_point_normal_tb
// Self-checking bench for the cubic Bezier point and unit normal evaluator.
// A directed table covers the reset state, the curve ends, parameters above
// one, full-scale control points and degenerate curves. It is followed by
// randomized configurations and parameter streams with sender gaps. Every
// result is compared field by field against the typed table entry or an
// integer model of the curve that is kept inside the bench.
// ----------------------------------------------------------------------------
module cubic_bezier_point_normal_tb
    import cbpn_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W = 16;
    localparam int FRAC_W  = 14;
    localparam int T_W     = FRAC_W + 1;
    localparam longint T_ONE    = 64'sd1 << FRAC_W;
    localparam longint HALF_LSB = 64'sd1 << (FRAC_W - 1);
    localparam longint COORD_HI = 64'sd32767;
    localparam longint COORD_LO = -64'sd32768;

    // Extra wait once the last pending result has arrived.
    localparam int DRAIN_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 150;
    localparam int MAX_MSG_LINES  = 40;

    // Sender idle percentage per random phase. The receiver cannot hold
    // results off, so the receiver-stall phases run back to back.
    localparam int SENDER_IDLE_PCT [RANDOM_PHASES] = '{0, 46, 0, 35, 46, 35};

    // Shapes of random control point sets.
    localparam int SHAPE_FREE  = 0;
    localparam int SHAPE_POINT = 1;
    localparam int SHAPE_TIED  = 2;

    // Control point sets used by the directed table.
    localparam logic [1:0] SET_RESET  = 2'd0;
    localparam logic [1:0] SET_BEND   = 2'd1;
    localparam logic [1:0] SET_RAIL   = 2'd2;
    localparam logic [1:0] SET_ZIGZAG = 2'd3;

    typedef logic [7:0][COORD_W-1:0] t_ctrl_set;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] normal_x;
        logic signed [COORD_W-1:0] normal_y;
        logic                      degenerate;
    } t_curve_sample;

    typedef struct packed {
        logic [1:0]     set_sel;
        logic [T_W-1:0] t;
        logic           typed;
        t_curve_sample  want;
    } t_dir_row;

    localparam t_curve_sample NO_WANT = '0;

    // Directed stimulus: typed results where they follow directly from the
    // curve ends, otherwise the bench model decides.
    localparam int DIR_ROWS_N = 25;
    localparam t_dir_row DIR_ROWS [DIR_ROWS_N] = '{
        // All control points zero after reset: point zero, degenerate.
        '{SET_RESET,  15'd0,     1'b1, '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1}},
        '{SET_RESET,  15'd16384, 1'b1, '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1}},
        '{SET_RESET,  15'd32767, 1'b1, '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1}},
        '{SET_RESET,  15'd8192,  1'b1, '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1}},
        // Bend: start tangent along +x, end tangent along +y.
        '{SET_BEND,   15'd0,     1'b1, '{16'h0000, 16'h0000, 16'h0000, 16'h4000, 1'b0}},
        '{SET_BEND,   15'd16384, 1'b1, '{16'h4000, 16'h4000, 16'hC000, 16'h0000, 1'b0}},
        '{SET_BEND,   15'd32767, 1'b1, '{16'h4000, 16'h4000, 16'hC000, 16'h0000, 1'b0}},
        '{SET_BEND,   15'd16385, 1'b1, '{16'h4000, 16'h4000, 16'hC000, 16'h0000, 1'b0}},
        '{SET_BEND,   15'd1,     1'b0, NO_WANT},
        '{SET_BEND,   15'd8192,  1'b0, NO_WANT},
        '{SET_BEND,   15'd16383, 1'b0, NO_WANT},
        '{SET_BEND,   15'd5461,  1'b0, NO_WANT},
        // Rail: all points at the positive x and negative y limits.
        '{SET_RAIL,   15'd0,     1'b1, '{16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 1'b1}},
        '{SET_RAIL,   15'd16384, 1'b1, '{16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 1'b1}},
        '{SET_RAIL,   15'd21000, 1'b1, '{16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 1'b1}},
        '{SET_RAIL,   15'd8192,  1'b0, NO_WANT},
        '{SET_RAIL,   15'd12345, 1'b0, NO_WANT},
        // Zigzag between opposite corners of the coordinate range.
        '{SET_ZIGZAG, 15'd0,     1'b0, NO_WANT},
        '{SET_ZIGZAG, 15'd1,     1'b0, NO_WANT},
        '{SET_ZIGZAG, 15'd4096,  1'b0, NO_WANT},
        '{SET_ZIGZAG, 15'd8192,  1'b0, NO_WANT},
        '{SET_ZIGZAG, 15'd12288, 1'b0, NO_WANT},
        '{SET_ZIGZAG, 15'd16384, 1'b0, NO_WANT},
        '{SET_ZIGZAG, 15'd32767, 1'b0, NO_WANT},
        '{SET_ZIGZAG, 15'd21845, 1'b0, NO_WANT}
    };

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [T_W-1:0]              i_param_t;
    logic                        i_cfg_we;
    logic [REG_IDX_W-1:0]        i_cfg_idx;
    logic [COORD_W-1:0]          i_cfg_data;
    logic                        o_strobe;
    logic signed [COORD_W-1:0]   o_point_x;
    logic signed [COORD_W-1:0]   o_point_y;
    logic signed [COORD_W-1:0]   o_normal_x;
    logic signed [COORD_W-1:0]   o_normal_y;
    logic                        o_degenerate;

    // Control points as the block holds them, updated at each write.
    logic signed [COORD_W-1:0] ctrl_shadow [8];
    t_curve_sample             pending_samples [$];

    int error_count   = 0;
    int msg_lines     = 0;
    int n_requests    = 0;
    int n_results     = 0;
    int n_degenerate  = 0;
    int n_saturated   = 0;
    int n_ctrl_sets   = 0;
    int idle_cycles   = 0;

    cubic_bezier_point_normal #(
        .COORD_BITS (COORD_W),
        .FRAC_BITS  (FRAC_W)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_param_t    (i_param_t),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_strobe     (o_strobe),
        .o_point_x    (o_point_x),
        .o_point_y    (o_point_y),
        .o_normal_x   (o_normal_x),
        .o_normal_y   (o_normal_y),
        .o_degenerate (o_degenerate)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Divide by 2^FRAC_W, rounding half away from zero.
    function automatic longint fx_round(input longint v);
        if (v >= 0) begin
            return (v + HALF_LSB) >>> FRAC_W;
        end
        return -((-v + HALF_LSB) >>> FRAC_W);
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > COORD_HI) begin
            return COORD_HI;
        end
        if (v < COORD_LO) begin
            return COORD_LO;
        end
        return v;
    endfunction

    // Floor of the square root, bit by bit.
    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned root = 0;
        longint unsigned bit_w = 64'd1 << 62;
        while (bit_w > x) bit_w >>= 2;
        while (bit_w != 0) begin
            if (x >= root + bit_w) begin
                x    -= root + bit_w;
                root  = (root >> 1) + bit_w;
            end else begin
                root >>= 1;
            end
            bit_w >>= 2;
        end
        return root;
    endfunction

    // Curve point and unit normal for parameter t under the shadow points.
    function automatic t_curve_sample eval_curve(input logic [T_W-1:0] t_raw);
        longint p_x [4];
        longint p_y [4];
        longint t, u, uu, tt, ut2, sx, sy, dx, dy, nx, ny;
        longint bw [4];
        longint unsigned ax, ay, mag, len, ux, uy;
        t_curve_sample r;
        p_x[0] = ctrl_shadow[REG_CTRL0_X];
        p_y[0] = ctrl_shadow[REG_CTRL0_Y];
        p_x[1] = ctrl_shadow[REG_CTRL1_X];
        p_y[1] = ctrl_shadow[REG_CTRL1_Y];
        p_x[2] = ctrl_shadow[REG_CTRL2_X];
        p_y[2] = ctrl_shadow[REG_CTRL2_Y];
        p_x[3] = ctrl_shadow[REG_CTRL3_X];
        p_y[3] = ctrl_shadow[REG_CTRL3_Y];

        // Parameters above one are taken as one.
        t = longint'(t_raw);
        if (t > T_ONE) t = T_ONE;
        u = T_ONE - t;

        // Bernstein weights and the point.
        uu    = fx_round(u * u);
        tt    = fx_round(t * t);
        ut2   = fx_round(2 * u * t);
        bw[0] = fx_round(uu * u);
        bw[1] = fx_round(3 * uu * t);
        bw[2] = fx_round(3 * u * tt);
        bw[3] = fx_round(tt * t);
        sx = 0;
        sy = 0;
        for (int k = 0; k < 4; k++) begin
            sx += bw[k] * p_x[k];
            sy += bw[k] * p_y[k];
        end

        // Derivative over three.
        dx = uu * (p_x[1] - p_x[0]) + ut2 * (p_x[2] - p_x[1]) + tt * (p_x[3] - p_x[2]);
        dy = uu * (p_y[1] - p_y[0]) + ut2 * (p_y[2] - p_y[1]) + tt * (p_y[3] - p_y[2]);

        nx = 0;
        ny = 0;
        r.degenerate = 1'b0;
        if (dx == 0 && dy == 0) begin
            r.degenerate = 1'b1;
        end else begin
            // Scale the larger magnitude into [2^30, 2^31) before the root.
            ax  = (dx < 0) ? -dx : dx;
            ay  = (dy < 0) ? -dy : dy;
            mag = (ax > ay) ? ax : ay;
            while (mag >= (64'd1 << 31)) begin
                mag >>= 1;
                ax  >>= 1;
                ay  >>= 1;
            end
            while (mag < (64'd1 << 30)) begin
                mag <<= 1;
                ax  <<= 1;
                ay  <<= 1;
            end
            len = int_sqrt(ax * ax + ay * ay);
            ux  = ((ax << FRAC_W) + (len >> 1)) / len;
            uy  = ((ay << FRAC_W) + (len >> 1)) / len;
            // Quarter turn: (-dy, dx).
            ny = (dx < 0) ? -longint'(ux) : longint'(ux);
            nx = (dy < 0) ? longint'(uy) : -longint'(uy);
        end
        r.point_x  = COORD_W'(clamp_coord(fx_round(sx)));
        r.point_y  = COORD_W'(clamp_coord(fx_round(sy)));
        r.normal_x = COORD_W'(clamp_coord(nx));
        r.normal_y = COORD_W'(clamp_coord(ny));
        return r;
    endfunction

    function automatic t_ctrl_set make_set(
        input logic [COORD_W-1:0] x0, input logic [COORD_W-1:0] y0,
        input logic [COORD_W-1:0] x1, input logic [COORD_W-1:0] y1,
        input logic [COORD_W-1:0] x2, input logic [COORD_W-1:0] y2,
        input logic [COORD_W-1:0] x3, input logic [COORD_W-1:0] y3
    );
        t_ctrl_set s;
        s[REG_CTRL0_X] = x0;
        s[REG_CTRL0_Y] = y0;
        s[REG_CTRL1_X] = x1;
        s[REG_CTRL1_Y] = y1;
        s[REG_CTRL2_X] = x2;
        s[REG_CTRL2_Y] = y2;
        s[REG_CTRL3_X] = x3;
        s[REG_CTRL3_Y] = y3;
        return s;
    endfunction

    function automatic t_ctrl_set directed_set(input logic [1:0] sel);
        unique case (sel)
            SET_BEND: begin
                return make_set(16'h0000, 16'h0000, 16'h2000, 16'h0000,
                                16'h4000, 16'h2000, 16'h4000, 16'h4000);
            end
            SET_RAIL: begin
                return make_set(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                                16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
            end
            SET_ZIGZAG: begin
                return make_set(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                                16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
            end
            default: begin
                return '0;
            end
        endcase
    endfunction

    // Coordinates lean on the limits, zero and tiny values.
    function automatic logic [COORD_W-1:0] pick_coord();
        unique case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return COORD_W'($signed($urandom_range(0, 14)) - 7);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic t_ctrl_set random_set(input int shape);
        t_ctrl_set s;
        for (int k = 0; k < 8; k++) s[k] = pick_coord();
        if (shape == SHAPE_POINT) begin
            // One point repeated: the derivative is zero everywhere.
            s = make_set(s[0], s[1], s[0], s[1], s[0], s[1], s[0], s[1]);
        end else if (shape == SHAPE_TIED) begin
            // Inner points on the end points: zero derivative at both ends.
            s[REG_CTRL1_X] = s[REG_CTRL0_X];
            s[REG_CTRL1_Y] = s[REG_CTRL0_Y];
            s[REG_CTRL2_X] = s[REG_CTRL3_X];
            s[REG_CTRL2_Y] = s[REG_CTRL3_Y];
        end
        return s;
    endfunction

    function automatic logic [T_W-1:0] pick_param();
        unique case ($urandom_range(0, 9))
            0: return '0;
            1: return T_W'(T_ONE);
            2: return T_W'($urandom_range(T_ONE + 1, (1 << T_W) - 1));
            3: return T_W'($urandom_range(0, 15));
            4: return T_W'($urandom_range(T_ONE - 15, T_ONE));
            default: return T_W'($urandom_range(0, T_ONE));
        endcase
    endfunction

    // Send one request and queue what it must produce.
    task automatic issue_request(input logic [T_W-1:0] t, input bit typed,
                                 input t_curve_sample want);
        start     <= 1'b1;
        i_param_t <= t;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_samples.push_back(typed ? want : eval_curve(t));
        n_requests++;
    endtask

    // Drop start, let every pending result arrive and the pipeline empty.
    task automatic drain_pipeline();
        start <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all eight control point registers, one per cycle.
    task automatic load_controls(input t_ctrl_set s);
        t_reg_idx reg_id = REG_CTRL0_X;
        repeat (8) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= reg_id;
            i_cfg_data <= s[reg_id];
            @(posedge i_clk);
            ctrl_shadow[reg_id] = s[reg_id];
            reg_id = reg_id.next();
        end
        i_cfg_we <= 1'b0;
        n_ctrl_sets++;
    endtask

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        if (msg_lines < MAX_MSG_LINES) begin
            $display("[%0t] result %0d %s: got %0d, expected %0d",
                     $realtime, n_results, what, got, want);
            msg_lines++;
        end
        error_count++;
    endtask

    // Result checker: each strobe takes the oldest expectation.
    always @(posedge i_clk) begin
        t_curve_sample want;
        if (i_rst_n && o_strobe) begin
            if (pending_samples.size() == 0) begin
                report_mismatch("with no request outstanding", 1, 0);
            end else begin
                want = pending_samples.pop_front();
                if (o_point_x !== want.point_x)
                    report_mismatch("point_x", o_point_x, want.point_x);
                if (o_point_y !== want.point_y)
                    report_mismatch("point_y", o_point_y, want.point_y);
                if (o_normal_x !== want.normal_x)
                    report_mismatch("normal_x", o_normal_x, want.normal_x);
                if (o_normal_y !== want.normal_y)
                    report_mismatch("normal_y", o_normal_y, want.normal_y);
                if (o_degenerate !== want.degenerate)
                    report_mismatch("degenerate", o_degenerate, want.degenerate);
                if (want.degenerate) n_degenerate++;
                if (want.point_x == COORD_HI || want.point_x == COORD_LO ||
                    want.point_y == COORD_HI || want.point_y == COORD_LO)
                    n_saturated++;
            end
            n_results++;
        end
    end

    // Watchdog on cycles with neither a request nor a result.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding",
                     pending_samples.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus.
    initial begin
        logic [1:0] cur_set;
        int         idle_pct;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_param_t  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= REG_CTRL0_X;
        i_cfg_data <= '0;
        for (int k = 0; k < 8; k++) ctrl_shadow[k] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, back to back within each control point set.
        cur_set = SET_RESET;
        for (int r = 0; r < DIR_ROWS_N; r++) begin
            if (DIR_ROWS[r].set_sel != cur_set) begin
                drain_pipeline();
                cur_set = DIR_ROWS[r].set_sel;
                load_controls(directed_set(cur_set));
            end
            issue_request(DIR_ROWS[r].t, DIR_ROWS[r].typed, DIR_ROWS[r].want);
        end

        // Random phases, each with its own control points and gap rate.
        // Each cycle is left idle with the phase's probability.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_pipeline();
            load_controls(random_set(p % 3));
            idle_pct = SENDER_IDLE_PCT[p];
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                    start     <= 1'b0;
                    i_param_t <= T_W'($urandom);
                    @(posedge i_clk);
                end
                issue_request(pick_param(), 1'b0, NO_WANT);
            end
        end

        drain_pipeline();
        $display("Covered %0d requests over %0d control point sets, %0d results checked.",
                 n_requests, n_ctrl_sets, n_results);
        $display("Degenerate normals: %0d, saturated points: %0d.",
                 n_degenerate, n_saturated);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
